[rtl/core/ptq_pkg.sv]
// ----------------------------------------------------------------------------
// ptq_pkg
// Types and constants shared by the task queue front end, back end and top.
// ----------------------------------------------------------------------------
package ptq_pkg;

    localparam int PRIO_W   = 2;
    localparam int SLOT_W   = 6;
    localparam int GEN_W    = 16;
    localparam int STATUS_W = 3;

    typedef enum logic [1:0] {
        OP_DISPATCH = 2'd0,
        OP_POP      = 2'd1,
        OP_RELEASE  = 2'd2,
        OP_NONE     = 2'd3
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 3'd0,
        ST_NO_SLOT = 3'd1,
        ST_FULL    = 3'd2,
        ST_EMPTY   = 3'd3,
        ST_STALE   = 3'd4,
        ST_OVER    = 3'd5
    } t_status;

    typedef enum logic [2:0] {
        BS_CLEAR,
        BS_IDLE,
        BS_STACK,
        BS_GEN,
        BS_QUEUE
    } t_bstate;

    typedef struct packed {
        t_op               op;
        logic [PRIO_W-1:0] prio;
        logic [SLOT_W-1:0] slot;
        logic              slot_ok;
        logic [GEN_W-1:0]  gen;
    } t_cmd;

endpackage

[rtl/core/priority_task_queue_slot_pool.sv]
// ----------------------------------------------------------------------------
// priority_task_queue_slot_pool
// Strict-priority task dispatcher over a pool of generation-tagged slots.
// ----------------------------------------------------------------------------
// After reset the block sweeps its slot memories, holding o_stall high,
// before it takes the first word. Each request word then gives exactly
// one result word. Requests pass through a two-entry queue into the
// execution unit, whose occupancy depends on the memory reads a request
// needs: none for a refused dispatch, an empty pop, an unknown opcode or a
// refused release, one queue or generation read for a pop or a release,
// and a free stack read followed by a generation read for an accepted
// dispatch. The result is held in an output register; a new request starts
// only when that register is empty or its result is being taken.
// ----------------------------------------------------------------------------
module priority_task_queue_slot_pool
    import ptq_pkg::*;
#(
    parameter int SLOTS           = 64,
    parameter int PRIORITY_LEVELS = 4,
    parameter int QUEUE_DEPTH     = 64,
    parameter int GEN_WIDTH       = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [1:0]          i_opcode,
    input  logic [PRIO_W-1:0]   i_priority_req,
    input  logic [SLOT_W-1:0]   i_slot_index,
    input  logic [GEN_W-1:0]    i_handle_generation,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [STATUS_W-1:0] o_status,
    output logic [SLOT_W-1:0]   o_task_slot,
    output logic [GEN_W-1:0]    o_task_generation,
    output logic                o_slot_freed
);

    logic cmd_valid;
    t_cmd cmd;
    logic cmd_take;
    logic busy;

    ptq_front #(
        .SLOTS           (SLOTS),
        .PRIORITY_LEVELS (PRIORITY_LEVELS)
    ) u_front (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_valid),
        .o_stall             (o_stall),
        .i_opcode            (i_opcode),
        .i_priority_req      (i_priority_req),
        .i_slot_index        (i_slot_index),
        .i_handle_generation (i_handle_generation),
        .i_busy              (busy),
        .o_cmd_valid         (cmd_valid),
        .o_cmd               (cmd),
        .i_cmd_take          (cmd_take)
    );

    ptq_back #(
        .SLOTS           (SLOTS),
        .PRIORITY_LEVELS (PRIORITY_LEVELS),
        .QUEUE_DEPTH     (QUEUE_DEPTH),
        .GEN_WIDTH       (GEN_WIDTH)
    ) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd_valid       (cmd_valid),
        .i_cmd             (cmd),
        .o_cmd_take        (cmd_take),
        .o_busy            (busy),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_status          (o_status),
        .o_task_slot       (o_task_slot),
        .o_task_generation (o_task_generation),
        .o_slot_freed      (o_slot_freed)
    );

endmodule

[rtl/core/ptq_front.sv]
// ----------------------------------------------------------------------------
// ptq_front
// Accepts request words, decodes them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module ptq_front
    import ptq_pkg::*;
#(
    parameter int SLOTS           = 64,
    parameter int PRIORITY_LEVELS = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [1:0]        i_opcode,
    input  logic [PRIO_W-1:0] i_priority_req,
    input  logic [SLOT_W-1:0] i_slot_index,
    input  logic [GEN_W-1:0]  i_handle_generation,
    input  logic              i_busy,
    output logic              o_cmd_valid,
    output t_cmd              o_cmd,
    input  logic              i_cmd_take
);

    t_cmd       r_q [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_cnt;
    t_cmd       cmd;
    logic       accept;

    always_comb begin
        cmd.op = t_op'(i_opcode);
        if (32'(i_priority_req) > 32'(PRIORITY_LEVELS - 1)) begin
            cmd.prio = PRIO_W'(PRIORITY_LEVELS - 1);
        end else begin
            cmd.prio = i_priority_req;
        end
        cmd.slot    = i_slot_index;
        cmd.slot_ok = (32'(i_slot_index) < 32'(SLOTS));
        cmd.gen     = i_handle_generation;
    end

    assign o_stall     = (r_cnt == 2'd2) || i_busy;
    assign accept      = i_valid && !o_stall;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_q[r_wr_ptr] <= cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            if (accept) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_cmd_take) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            case ({accept, i_cmd_take})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

[rtl/core/ptq_back.sv]
// ----------------------------------------------------------------------------
// ptq_back
// Executes decoded requests against the slot pool, free stack and priority
// queues, and holds the result word until it is taken.
// ----------------------------------------------------------------------------
module ptq_back
    import ptq_pkg::*;
#(
    parameter int SLOTS           = 64,
    parameter int PRIORITY_LEVELS = 4,
    parameter int QUEUE_DEPTH     = 64,
    parameter int GEN_WIDTH       = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cmd_valid,
    input  t_cmd                i_cmd,
    output logic                o_cmd_take,
    output logic                o_busy,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [STATUS_W-1:0] o_status,
    output logic [SLOT_W-1:0]   o_task_slot,
    output logic [GEN_W-1:0]    o_task_generation,
    output logic                o_slot_freed
);

    localparam int SW   = $clog2(SLOTS);
    localparam int FW   = $clog2(SLOTS + 1);
    localparam int LW   = (PRIORITY_LEVELS > 1) ? $clog2(PRIORITY_LEVELS) : 1;
    localparam int QW   = $clog2(QUEUE_DEPTH);
    localparam int CW   = $clog2(QUEUE_DEPTH + 1);
    localparam int QAW  = LW + QW;
    localparam int QMEM = 2 ** QAW;
    localparam int GW   = GEN_WIDTH;

    logic [GW:0]      gen_mem [SLOTS];
    logic [SW-1:0]    stk_mem [SLOTS];
    logic [SW+GW-1:0] q_mem   [QMEM];

    t_bstate          r_state, n_state;
    logic [SW-1:0]    r_clr, n_clr;
    logic [FW-1:0]    r_free_cnt, n_free_cnt;
    logic [QW-1:0]    r_head [PRIORITY_LEVELS];
    logic [QW-1:0]    n_head [PRIORITY_LEVELS];
    logic [QW-1:0]    r_tail [PRIORITY_LEVELS];
    logic [QW-1:0]    n_tail [PRIORITY_LEVELS];
    logic [CW-1:0]    r_cnt  [PRIORITY_LEVELS];
    logic [CW-1:0]    n_cnt  [PRIORITY_LEVELS];
    t_cmd             r_cmd, n_cmd;
    logic [SW-1:0]    r_slot, n_slot;
    logic [QAW-1:0]   r_qaddr, n_qaddr;

    logic             r_out_valid, n_out_valid;
    t_status          r_status, n_status;
    logic [SLOT_W-1:0] r_out_slot, n_out_slot;
    logic [GEN_W-1:0] r_out_gen, n_out_gen;
    logic             r_out_freed, n_out_freed;

    logic [GW:0]      r_gen_rd;
    logic [SW-1:0]    r_stk_rd;
    logic [SW+GW-1:0] r_q_rd;

    logic             gen_we, gen_re, stk_we, stk_re, q_we, q_re;
    logic [SW-1:0]    gen_waddr, gen_raddr, stk_waddr, stk_raddr;
    logic [GW:0]      gen_wdata;
    logic [SW-1:0]    stk_wdata;
    logic [QAW-1:0]   q_waddr, q_raddr;
    logic [SW+GW-1:0] q_wdata;

    logic [LW-1:0]    pop_lvl;
    logic             any_ne;
    logic [LW-1:0]    disp_lvl;
    logic             out_free;
    logic [GW-1:0]    gen_cur;
    logic [GW-1:0]    gen_inc;

    always_comb begin
        pop_lvl = '0;
        any_ne  = 1'b0;
        for (int i = 0; i < PRIORITY_LEVELS; i++) begin
            if (r_cnt[i] != '0) begin
                pop_lvl = LW'(i);
                any_ne  = 1'b1;
            end
        end
    end

    assign disp_lvl = LW'(32'(i_cmd.prio));
    assign out_free = !r_out_valid || !i_stall;
    assign gen_cur  = r_gen_rd[GW-1:0];
    assign gen_inc  = gen_cur + GW'(1);

    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_free_cnt  = r_free_cnt;
        n_head      = r_head;
        n_tail      = r_tail;
        n_cnt       = r_cnt;
        n_cmd       = r_cmd;
        n_slot      = r_slot;
        n_qaddr     = r_qaddr;
        n_out_valid = r_out_valid && i_stall;
        n_status    = r_status;
        n_out_slot  = r_out_slot;
        n_out_gen   = r_out_gen;
        n_out_freed = r_out_freed;
        o_cmd_take  = 1'b0;
        gen_we      = 1'b0;
        gen_re      = 1'b0;
        stk_we      = 1'b0;
        stk_re      = 1'b0;
        q_we        = 1'b0;
        q_re        = 1'b0;
        gen_waddr   = r_slot;
        gen_raddr   = r_slot;
        gen_wdata   = '0;
        stk_waddr   = SW'(r_free_cnt);
        stk_raddr   = SW'(r_free_cnt - FW'(1));
        stk_wdata   = r_slot;
        q_waddr     = r_qaddr;
        q_raddr     = {pop_lvl, r_head[pop_lvl]};
        q_wdata     = {r_slot, gen_inc};

        case (r_state)
            BS_CLEAR: begin
                gen_we    = 1'b1;
                gen_waddr = r_clr;
                gen_wdata = '0;
                stk_we    = 1'b1;
                stk_waddr = r_clr;
                stk_wdata = SW'(SLOTS - 1) - r_clr;
                if (r_clr == SW'(SLOTS - 1)) begin
                    n_state = BS_IDLE;
                end else begin
                    n_clr = r_clr + SW'(1);
                end
            end
            BS_IDLE: begin
                if (i_cmd_valid && out_free) begin
                    o_cmd_take  = 1'b1;
                    n_cmd       = i_cmd;
                    n_status    = ST_OK;
                    n_out_slot  = '0;
                    n_out_gen   = '0;
                    n_out_freed = 1'b0;
                    case (i_cmd.op)
                        OP_DISPATCH: begin
                            if (r_free_cnt == '0) begin
                                n_out_valid = 1'b1;
                                n_status    = ST_NO_SLOT;
                            end else if (r_cnt[disp_lvl] == CW'(QUEUE_DEPTH)) begin
                                n_out_valid = 1'b1;
                                n_status    = ST_FULL;
                            end else begin
                                stk_re           = 1'b1;
                                n_free_cnt       = r_free_cnt - FW'(1);
                                n_qaddr          = {disp_lvl, r_tail[disp_lvl]};
                                n_cnt[disp_lvl]  = r_cnt[disp_lvl] + CW'(1);
                                n_tail[disp_lvl] = (r_tail[disp_lvl] == QW'(QUEUE_DEPTH - 1))
                                                   ? '0 : r_tail[disp_lvl] + QW'(1);
                                n_state          = BS_STACK;
                            end
                        end
                        OP_POP: begin
                            if (any_ne) begin
                                q_re            = 1'b1;
                                n_cnt[pop_lvl]  = r_cnt[pop_lvl] - CW'(1);
                                n_head[pop_lvl] = (r_head[pop_lvl] == QW'(QUEUE_DEPTH - 1))
                                                  ? '0 : r_head[pop_lvl] + QW'(1);
                                n_state         = BS_QUEUE;
                            end else begin
                                n_out_valid = 1'b1;
                                n_status    = ST_EMPTY;
                            end
                        end
                        OP_RELEASE: begin
                            if (!i_cmd.slot_ok) begin
                                n_out_valid = 1'b1;
                                n_status    = ST_STALE;
                            end else begin
                                gen_re    = 1'b1;
                                gen_raddr = SW'(32'(i_cmd.slot));
                                n_slot    = SW'(32'(i_cmd.slot));
                                n_state   = BS_GEN;
                            end
                        end
                        default: begin
                            n_out_valid = 1'b1;
                        end
                    endcase
                end
            end
            BS_STACK: begin
                gen_re    = 1'b1;
                gen_raddr = r_stk_rd;
                n_slot    = r_stk_rd;
                n_state   = BS_GEN;
            end
            BS_GEN: begin
                n_out_valid = 1'b1;
                n_state     = BS_IDLE;
                if (r_cmd.op == OP_DISPATCH) begin
                    gen_we     = 1'b1;
                    gen_wdata  = {1'b1, gen_inc};
                    q_we       = 1'b1;
                    n_status   = ST_OK;
                    n_out_slot = SLOT_W'(32'(r_slot));
                    n_out_gen  = GEN_W'(32'(gen_inc));
                end else if (32'(gen_cur) != 32'(r_cmd.gen)) begin
                    n_status = ST_STALE;
                end else if (!r_gen_rd[GW] || r_free_cnt == FW'(SLOTS)) begin
                    n_status = ST_OVER;
                end else begin
                    gen_we      = 1'b1;
                    gen_wdata   = {1'b0, gen_inc};
                    stk_we      = 1'b1;
                    n_free_cnt  = r_free_cnt + FW'(1);
                    n_status    = ST_OK;
                    n_out_freed = 1'b1;
                end
            end
            BS_QUEUE: begin
                n_out_valid = 1'b1;
                n_status    = ST_OK;
                n_out_slot  = SLOT_W'(32'(r_q_rd[SW+GW-1:GW]));
                n_out_gen   = GEN_W'(32'(r_q_rd[GW-1:0]));
                n_state     = BS_IDLE;
            end
            default: begin
                n_state = BS_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (gen_we) begin
            gen_mem[gen_waddr] <= gen_wdata;
        end
        if (gen_re) begin
            r_gen_rd <= gen_mem[gen_raddr];
        end
        if (stk_we) begin
            stk_mem[stk_waddr] <= stk_wdata;
        end
        if (stk_re) begin
            r_stk_rd <= stk_mem[stk_raddr];
        end
        if (q_we) begin
            q_mem[q_waddr] <= q_wdata;
        end
        if (q_re) begin
            r_q_rd <= q_mem[q_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd       <= n_cmd;
        r_slot      <= n_slot;
        r_qaddr     <= n_qaddr;
        r_status    <= n_status;
        r_out_slot  <= n_out_slot;
        r_out_gen   <= n_out_gen;
        r_out_freed <= n_out_freed;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BS_CLEAR;
            r_clr       <= '0;
            r_free_cnt  <= FW'(SLOTS);
            r_out_valid <= 1'b0;
            for (int i = 0; i < PRIORITY_LEVELS; i++) begin
                r_head[i] <= '0;
                r_tail[i] <= '0;
                r_cnt[i]  <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_free_cnt  <= n_free_cnt;
            r_out_valid <= n_out_valid;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_cnt       <= n_cnt;
        end
    end

    assign o_busy            = (r_state == BS_CLEAR);
    assign o_valid           = r_out_valid;
    assign o_status          = r_status;
    assign o_task_slot       = r_out_slot;
    assign o_task_generation = r_out_gen;
    assign o_slot_freed      = r_out_freed;

endmodule
